// ===== hdl/cmi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calibrated meter interpolator package
// Shared codes, register reset values and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cmi_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MEAS = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_VOLTAGE  = 2'd0;
  localparam logic [1:0] KIND_CURRENT  = 2'd1;
  localparam logic [1:0] KIND_SETPOINT = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_VOLTAGE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CURRENT  = 3'd4;

  // Register reset values.
  localparam logic [15:0] RST_VOLTAGE_GAIN = 16'd14000;
  localparam logic [15:0] RST_CURRENT_GAIN = 16'd2500;
  localparam logic [15:0] RST_LIMIT_MARGIN = 16'd100;
  localparam logic [15:0] RST_LOW_VOLTAGE  = 16'd400;
  localparam logic [15:0] RST_MIN_CURRENT  = 16'd100;

  // The divider retires two quotient bits per cycle over a 16-bit quotient.
  localparam int unsigned DIV_STEPS = 8;

  typedef struct packed {
    logic accept;
    logic search;
    logic mul1;
    logic mul2;
    logic mul3;
    logic prep;
    logic div_step;
    logic finish;
  } cmi_cmd_t;

  typedef struct packed {
    logic found;
    logic out_busy;
  } cmi_sts_t;

endpackage
`default_nettype wire

// ===== hdl/cmi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calibrated meter interpolator controller
// Sequences one item at a time through search, multiply, divide and result.
// ----------------------------------------------------------------------------
module cmi_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     op_i,
  input  cmi_pkg::cmi_sts_t   sts_i,
  output cmi_pkg::cmi_cmd_t   cmd_o
);
  import cmi_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SEARCH = 8'b0000_0010,
    ST_MUL1   = 8'b0000_0100,
    ST_MUL2   = 8'b0000_1000,
    ST_MUL3   = 8'b0001_0000,
    ST_PREP   = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  localparam int unsigned CntW = $clog2(DIV_STEPS);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_MEAS) begin
            state_d = ST_SEARCH;
          end else if (op_i == OP_SET) begin
            state_d = ST_MUL2;
          end
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.found) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cmi_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calibrated meter interpolator datapath
// Calibration table memory, segment search, interpolation multipliers,
// radix-4 restoring divider, limit logic and the result register.
// ----------------------------------------------------------------------------
module cmi_dp #(
  parameter int unsigned SEGMENTS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  cmi_pkg::cmi_cmd_t                   cmd_i,
  output cmi_pkg::cmi_sts_t                   sts_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [cmi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [15:0]                    cfg_data_i,
  input  wire logic [1:0]                     op_i,
  input  wire logic                           channel_i,
  input  wire logic [3:0]                     point_index_i,
  input  wire logic [12:0]                    out_point_i,
  input  wire logic [12:0]                    in_point_i,
  input  wire logic [11:0]                    sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          kind_o,
  output logic [15:0]                         value_o,
  output logic                                limit_flag_o
);
  import cmi_pkg::*;

  localparam int unsigned Npts  = SEGMENTS + 1;
  localparam int unsigned Depth = 2 * Npts;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned PtW   = $clog2(SEGMENTS + 1);

  // Configuration registers.
  logic [15:0] vgain_q, cgain_q, margin_q, lowv_q, minc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vgain_q  <= RST_VOLTAGE_GAIN;
      cgain_q  <= RST_CURRENT_GAIN;
      margin_q <= RST_LIMIT_MARGIN;
      lowv_q   <= RST_LOW_VOLTAGE;
      minc_q   <= RST_MIN_CURRENT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VOLTAGE_GAIN: vgain_q  <= cfg_data_i;
        CFG_CURRENT_GAIN: cgain_q  <= cfg_data_i;
        CFG_LIMIT_MARGIN: margin_q <= cfg_data_i;
        CFG_LOW_VOLTAGE:  lowv_q   <= cfg_data_i;
        CFG_MIN_CURRENT:  minc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched item.
  logic [1:0]  op_q;
  logic        ch_q;
  logic [11:0] x_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= op_i;
      ch_q <= channel_i;
      x_q  <= sample_i;
    end
  end

  // Reset value of each point: evenly spaced over the 12-bit input range.
  logic [12:0] rst_tab [0:SEGMENTS];
  for (genvar g = 0; g <= SEGMENTS; g++) begin : g_rst
    localparam int unsigned RstVal = (g * 4096) / SEGMENTS;
    assign rst_tab[g] = 13'(RstVal);
  end

  // Table memory: {out_point, in_point}; an entry never written reads as
  // its reset value through the valid bits.
  logic [25:0]      mem_q [0:Depth-1];
  logic [Depth-1:0] vld_q;
  logic [25:0]      rdata_q;
  logic             rvld_q;
  logic [AddrW-1:0] waddr, raddr;
  logic             wen;
  logic [PtW-1:0]   rd_ptr_q, rd_pt_q;
  logic             pend_q;

  assign wen   = cmd_i.accept && (op_i == OP_LOAD) && (32'(point_index_i) <= SEGMENTS);
  assign waddr = channel_i ? AddrW'(Npts) + AddrW'(point_index_i) : AddrW'(point_index_i);
  assign raddr = ch_q ? AddrW'(Npts) + AddrW'(rd_ptr_q) : AddrW'(rd_ptr_q);

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[waddr] <= {out_point_i, in_point_i};
    end
    rdata_q <= mem_q[raddr];
    rvld_q  <= vld_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wen) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  // Segment search: points are read in order; the first point at or above
  // the sample, or the last point, closes the segment.
  logic [12:0] eff_in, eff_out;
  logic        stop;
  logic [12:0] x0_q, y0_q, x1_q, y1_q;

  assign eff_in  = rvld_q ? rdata_q[12:0]  : rst_tab[rd_pt_q];
  assign eff_out = rvld_q ? rdata_q[25:13] : rst_tab[rd_pt_q];
  assign stop    = pend_q && (rd_pt_q != '0) &&
                   ((rd_pt_q == PtW'(SEGMENTS)) || !({1'b0, x_q} > eff_in));
  assign sts_o.found = cmd_i.search && stop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      rd_ptr_q <= '0;
      rd_pt_q  <= '0;
    end else if (cmd_i.accept) begin
      pend_q   <= 1'b0;
      rd_ptr_q <= '0;
    end else if (cmd_i.search) begin
      pend_q  <= 1'b1;
      rd_pt_q <= rd_ptr_q;
      if (rd_ptr_q != PtW'(SEGMENTS)) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search && pend_q) begin
      if (stop) begin
        x1_q <= eff_in;
        y1_q <= eff_out;
      end else begin
        x0_q <= eff_in;
        y0_q <= eff_out;
      end
    end
  end

  // Interpolation arithmetic.
  logic signed [13:0] den, dy, dx, den_q;
  logic signed [27:0] p1_q, p2_q, sum, num_d, num_q;
  logic [12:0]        dabs_d, dabs_q;
  logic [15:0]        gain;
  logic signed [44:0] prod_q;

  assign den = $signed({1'b0, x1_q}) - $signed({1'b0, x0_q});
  assign dy  = $signed({1'b0, y1_q}) - $signed({1'b0, y0_q});
  assign dx  = $signed({2'b00, x_q}) - $signed({1'b0, x0_q});
  assign sum = p1_q + p2_q;

  always_comb begin
    priority if (op_q == OP_SET) begin
      num_d  = $signed({16'd0, x_q});
      dabs_d = 13'd1;
    end else if (den_q == '0) begin
      // A zero-width segment takes its lower output point.
      num_d  = $signed({15'd0, y0_q});
      dabs_d = 13'd1;
    end else if (den_q < 0) begin
      num_d  = -sum;
      dabs_d = 13'(-den_q);
    end else begin
      num_d  = sum;
      dabs_d = den_q[12:0];
    end
  end

  assign gain = ((op_q == OP_SET) || ch_q) ? cgain_q : vgain_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      den_q <= den;
      p1_q  <= 28'($signed({1'b0, y0_q})) * 28'(den);
      p2_q  <= 28'(dy) * 28'(dx);
    end
    if (cmd_i.mul2) begin
      num_q  <= num_d;
      dabs_q <= dabs_d;
    end
    if (cmd_i.mul3) begin
      prod_q <= 45'(num_q) * 45'($signed({1'b0, gain}));
    end
  end

  // Rounded division by dabs * 4096, done as a shift then a divide by dabs.
  logic signed [44:0] rnd;
  logic [31:0]        np;
  logic               zero_q, sat_q;
  logic [12:0]        rem_q, rem_d;
  logic [15:0]        quo_q, quo_d;

  assign rnd = prod_q + $signed({21'd0, dabs_q, 11'd0});
  assign np  = rnd[43:12];

  always_comb begin
    logic [13:0] r2;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < 2; k++) begin
      r2    = {rem_d, quo_d[15]};
      quo_d = {quo_d[14:0], 1'b0};
      if (r2 >= {1'b0, dabs_q}) begin
        rem_d    = 13'(r2 - {1'b0, dabs_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = r2[12:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      zero_q <= prod_q[44] || (prod_q == '0);
      sat_q  <= np[31:16] >= {3'd0, dabs_q};
      rem_q  <= np[28:16];
      quo_q  <= np[15:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Result, latest values and limit flag.
  logic [15:0]        res;
  logic [15:0]        lastv_q, lastc_q, lasts_q, lastv_d, lastc_d, lasts_d;
  logic signed [16:0] thr;
  logic               flag;
  logic               out_valid_q;
  logic [1:0]         kind_d;

  assign res = zero_q ? 16'd0 : (sat_q ? 16'hFFFF : quo_q);

  always_comb begin
    lastv_d = lastv_q;
    lastc_d = lastc_q;
    lasts_d = lasts_q;
    priority if (op_q == OP_SET) begin
      lasts_d = res;
      kind_d  = KIND_SETPOINT;
    end else if (ch_q) begin
      lastc_d = res;
      kind_d  = KIND_CURRENT;
    end else begin
      lastv_d = res;
      kind_d  = KIND_VOLTAGE;
    end
  end

  assign thr  = $signed({1'b0, lasts_d}) - $signed({1'b0, margin_q});
  assign flag = ($signed({1'b0, lastc_d}) > thr) && (lastv_d < lowv_q) && (lastc_d > minc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lastv_q     <= '0;
      lastc_q     <= '0;
      lasts_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        lastv_q     <= lastv_d;
        lastc_q     <= lastc_d;
        lasts_q     <= lasts_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      kind_o       <= kind_d;
      value_o      <= res;
      limit_flag_o <= flag;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule
`default_nettype wire

// ===== hdl/calibrated_meter_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calibrated meter interpolator
// Two-channel piecewise linear calibration with gain, clamp and limit flag.
// ----------------------------------------------------------------------------
// The block handles one item at a time. A load item writes one calibration
// point in its accept cycle and is done. A measured sample walks the table
// through the one-read-port point memory, one point per cycle, then passes
// through the multiplier states, rounding setup and the two-bit-per-cycle
// divider; its result enters the output register once that register is
// free. A setpoint sample skips the search and the first multiplier state.
// The next item is accepted as soon as the result is registered, while that
// result still waits to be taken.
module calibrated_meter_interpolator #(
  parameter int unsigned SEGMENTS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cmi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [15:0]                    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     op_i,
  input  wire logic                           channel_i,
  input  wire logic [3:0]                     point_index_i,
  input  wire logic [12:0]                    out_point_i,
  input  wire logic [12:0]                    in_point_i,
  input  wire logic [11:0]                    sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          kind_o,
  output logic [15:0]                         value_o,
  output logic                                limit_flag_o
);
  import cmi_pkg::*;

  cmi_cmd_t cmd;
  cmi_sts_t sts;

  cmi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cmi_dp #(
    .SEGMENTS (SEGMENTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op_i),
    .channel_i     (channel_i),
    .point_index_i (point_index_i),
    .out_point_i   (out_point_i),
    .in_point_i    (in_point_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .limit_flag_o  (limit_flag_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/meter_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibrated meter result checker
// Watches the configuration port and both item channels of the meter. It
// keeps its own copy of the calibration tables, registers and latest
// readings, predicts every result and compares it with what leaves the block.
// ----------------------------------------------------------------------------
module meter_result_checker #(
  parameter int unsigned SEGMENTS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cmi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]                   cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [1:0]                    op_i,
  input  wire logic                          channel_i,
  input  wire logic [3:0]                    point_index_i,
  input  wire logic [12:0]                   out_point_i,
  input  wire logic [12:0]                   in_point_i,
  input  wire logic [11:0]                   sample_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [15:0]                   value_i,
  input  wire logic                          limit_flag_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);
  import cmi_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic        limit_flag;
  } meter_result_t;

  meter_result_t expected_results[$];

  logic [12:0] out_axis[2][SEGMENTS+1];
  logic [12:0] in_axis[2][SEGMENTS+1];
  logic [15:0] last_volt, last_curr, last_setp;
  logic [15:0] volt_gain, curr_gain, margin, low_volt, min_curr;
  int          fails = 0;
  int          checked = 0;

  // Rounds a positive ratio to nearest, halves up, and clamps to 16 bits.
  function automatic logic [15:0] round_clamp(longint num, longint den);
    longint q;
    if (num <= 0) return '0;
    q = (num + den / 2) / den;
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  function automatic logic [15:0] interpolate(int ch, longint x, longint gain);
    int     seg;
    longint x0, x1, y0, y1, den, num;
    seg = 0;
    // The search never passes the last segment, so samples above the
    // table extrapolate from it.
    while (seg < SEGMENTS - 1 && x > in_axis[ch][seg+1]) seg++;
    x0 = in_axis[ch][seg];
    x1 = in_axis[ch][seg+1];
    y0 = out_axis[ch][seg];
    y1 = out_axis[ch][seg+1];
    den = x1 - x0;
    if (den == 0) begin
      num = y0;
      den = 1;
    end else begin
      num = y0 * den + (y1 - y0) * (x - x0);
      if (den < 0) begin
        den = -den;
        num = -num;
      end
    end
    return round_clamp(num * gain, den * 4096);
  endfunction

  function automatic logic limit_active();
    int cur, sp, mg;
    cur = last_curr;
    sp = last_setp;
    mg = margin;
    return (cur > sp - mg) && (last_volt < low_volt) && (last_curr > min_curr);
  endfunction

  task automatic reset_model();
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i <= SEGMENTS; i++) begin
        out_axis[c][i] = 13'((i * 4096) / SEGMENTS);
        in_axis[c][i] = 13'((i * 4096) / SEGMENTS);
      end
    end
    last_volt = '0;
    last_curr = '0;
    last_setp = '0;
    volt_gain = RST_VOLTAGE_GAIN;
    curr_gain = RST_CURRENT_GAIN;
    margin = RST_LIMIT_MARGIN;
    low_volt = RST_LOW_VOLTAGE;
    min_curr = RST_MIN_CURRENT;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    meter_result_t want, got;
    logic [15:0]   val;
    if (!rst_ni) begin
      reset_model();
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VOLTAGE_GAIN: volt_gain = cfg_data_i;
          CFG_CURRENT_GAIN: curr_gain = cfg_data_i;
          CFG_LIMIT_MARGIN: margin = cfg_data_i;
          CFG_LOW_VOLTAGE:  low_volt = cfg_data_i;
          CFG_MIN_CURRENT:  min_curr = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        got = '{kind: kind_i, value: value_i, limit_flag: limit_flag_i};
        if (expected_results.size() == 0) begin
          $error("result with no item pending: kind %0d value %0d limit_flag %0d",
                 kind_i, value_i, limit_flag_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            fails++;
          end
          if (got.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, got.value);
            fails++;
          end
          if (got.limit_flag !== want.limit_flag) begin
            $error("limit_flag: expected %0d, actual %0d", want.limit_flag,
                   got.limit_flag);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        case (op_i)
          OP_LOAD: begin
            if (point_index_i <= SEGMENTS) begin
              out_axis[channel_i][point_index_i] = out_point_i;
              in_axis[channel_i][point_index_i] = in_point_i;
            end
          end
          OP_MEAS: begin
            val = interpolate(channel_i, sample_i, channel_i ? curr_gain : volt_gain);
            if (channel_i) last_curr = val;
            else last_volt = val;
            want.kind = channel_i ? KIND_CURRENT : KIND_VOLTAGE;
            want.value = val;
            want.limit_flag = limit_active();
            expected_results.push_back(want);
          end
          OP_SET: begin
            val = round_clamp(longint'(sample_i) * longint'(curr_gain), 4096);
            last_setp = val;
            want.kind = KIND_SETPOINT;
            want.value = val;
            want.limit_flag = limit_active();
            expected_results.push_back(want);
          end
          default: ;
        endcase
      end

      pending_o <= expected_results.size();
      fail_count_o <= fails;
      checked_o <= checked;
    end
  end

endmodule

// ===== tb/sv/calibrated_meter_interpolator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibrated meter interpolator testbench
// Drives table loads, measured samples and setpoint samples through the
// meter, first a directed set of corner cases and then random traffic over
// several register settings and idle patterns. A separate checker predicts
// and compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module calibrated_meter_interpolator_test;
  import cmi_pkg::*;

  localparam int unsigned SEGMENTS = 8;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic CH_VOLTAGE = 1'b0;
  localparam logic CH_CURRENT = 1'b1;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    logic [1:0]  op;
    logic        channel;
    logic [3:0]  point_index;
    logic [12:0] out_point;
    logic [12:0] in_point;
    logic [11:0] sample;
  } meter_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [15:0]          cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic [1:0]           op_i = '0;
  logic                 channel_i = 1'b0;
  logic [3:0]           point_index_i = '0;
  logic [12:0]          out_point_i = '0;
  logic [12:0]          in_point_i = '0;
  logic [11:0]          sample_i = '0;
  logic                 out_ready_i = 1'b0;
  wire logic            in_ready_o;
  wire logic            out_valid_o;
  wire logic [1:0]      kind_o;
  wire logic [15:0]     value_o;
  wire logic            limit_flag_o;

  int   fail_count, pending, checked;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic hold_kick = 1'b0;
  logic kick_seen = 1'b0;
  int   hold_left = 0;
  int   items_sent = 0;
  int   loads_sent = 0;
  int   conversions_sent = 0;
  int   reg_writes = 0;

  always #5 clk_i = ~clk_i;

  calibrated_meter_interpolator #(.SEGMENTS(SEGMENTS)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .op_i, .channel_i, .point_index_i,
    .out_point_i, .in_point_i, .sample_i,
    .out_valid_o, .out_ready_i, .kind_o, .value_o, .limit_flag_o
  );

  meter_result_checker #(.SEGMENTS(SEGMENTS)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .op_i, .channel_i, .point_index_i,
    .out_point_i, .in_point_i, .sample_i,
    .out_valid_i(out_valid_o), .out_ready_i, .kind_i(kind_o), .value_i(value_o),
    .limit_flag_i(limit_flag_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Result receiver. A toggle of hold_kick starts a long hold-off so that the
  // block backs up and stalls its input.
  always @(posedge clk_i) begin
    if (hold_kick != kick_seen) begin
      kick_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic meter_item_t mk(logic [1:0] op, logic ch, logic [3:0] idx,
                                     logic [12:0] outp, logic [12:0] inp,
                                     logic [11:0] smp);
    meter_item_t it;
    it.op = op;
    it.channel = ch;
    it.point_index = idx;
    it.out_point = outp;
    it.in_point = inp;
    it.sample = smp;
    return it;
  endfunction

  // Table values mostly stay near an ordered grid; coarse grid values make
  // neighbors collide into zero-width segments now and then.
  function automatic logic [12:0] axis_value(int idx);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = idx * 512 + int'($urandom_range(0, 400)) - 200;
        v = (v < 0) ? 0 : ((v > 4096) ? 4096 : v);
      end
      4, 5, 6: v = 512 * $urandom_range(0, 8);
      7, 8:    v = $urandom_range(0, 4096);
      default: v = $urandom_range(0, 8191);
    endcase
    return v[12:0];
  endfunction

  function automatic meter_item_t rand_item();
    meter_item_t it;
    int          r, v;
    it = mk(OP_MEAS, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
            13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
            12'($urandom_range(0, 4095)));
    r = $urandom_range(0, 99);
    if (r < 20) begin
      it.op = OP_LOAD;
      it.point_index = ($urandom_range(0, 14) == 0) ? 4'($urandom_range(9, 15))
                                                    : 4'($urandom_range(0, 8));
      it.in_point = axis_value(it.point_index);
      it.out_point = axis_value(it.point_index);
    end else if (r < 80) begin
      // Samples near grid points land on segment boundaries.
      if ($urandom_range(0, 9) < 3) begin
        v = 512 * $urandom_range(0, 8) + int'($urandom_range(0, 6)) - 3;
        it.sample = (v < 0) ? 12'd0 : ((v > 4095) ? 12'd4095 : 12'(v));
      end
    end else if (r < 97) begin
      it.op = OP_SET;
    end else begin
      it.op = OP_NONE;
    end
    return it;
  endfunction

  task automatic send_item(meter_item_t it);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    op_i <= it.op;
    channel_i <= it.channel;
    point_index_i <= it.point_index;
    out_point_i <= it.out_point;
    in_point_i <= it.in_point;
    sample_i <= it.sample;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (it.op == OP_LOAD) loads_sent++;
    if (it.op == OP_MEAS || it.op == OP_SET) conversions_sent++;
  endtask

  // Waits until every expected result is in, then lets the block finish any
  // work that gives no result before registers may change.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    reg_writes++;
  endtask

  task automatic write_regs(logic [15:0] vg, logic [15:0] cg, logic [15:0] lm,
                            logic [15:0] lv, logic [15:0] mc);
    put_reg(CFG_VOLTAGE_GAIN, vg);
    put_reg(CFG_CURRENT_GAIN, cg);
    put_reg(CFG_LIMIT_MARGIN, lm);
    put_reg(CFG_LOW_VOLTAGE, lv);
    put_reg(CFG_MIN_CURRENT, mc);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n, bit pressure);
    meter_item_t it;
    int          done;
    done = 0;
    tx_idle_pct = idle_pct;
    rx_stall_pct <= stall_pct;
    if (pressure) hold_kick <= ~hold_kick;
    // Ignored items do not count toward the phase length.
    while (done < n) begin
      it = rand_item();
      send_item(it);
      if (it.op == OP_MEAS || it.op == OP_SET ||
          (it.op == OP_LOAD && it.point_index <= SEGMENTS)) done++;
    end
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases on the reset tables and registers.
    send_item(mk(OP_MEAS, CH_VOLTAGE, 4'd0, 13'd0, 13'd0, 12'd0));
    send_item(mk(OP_MEAS, CH_VOLTAGE, 4'd15, 13'd8191, 13'd8191, 12'd4095));
    send_item(mk(OP_MEAS, CH_CURRENT, 4'd0, 13'd0, 13'd0, 12'd2048));
    send_item(mk(OP_SET, CH_CURRENT, 4'd0, 13'd0, 13'd0, 12'd0));
    send_item(mk(OP_SET, CH_VOLTAGE, 4'd0, 13'd0, 13'd0, 12'd4095));
    send_item(mk(OP_NONE, CH_CURRENT, 4'd3, 13'd100, 13'd100, 12'd1234));
    send_item(mk(OP_LOAD, CH_VOLTAGE, 4'd9, 13'd8191, 13'd8191, 12'd0));
    send_item(mk(OP_LOAD, CH_VOLTAGE, 4'd15, 13'd4096, 13'd4096, 12'd4095));
    send_item(mk(OP_MEAS, CH_VOLTAGE, 4'd0, 13'd0, 13'd0, 12'd4095));
    // Zero-width first segment on the current table.
    send_item(mk(OP_LOAD, CH_CURRENT, 4'd0, 13'd300, 13'd100, 12'd0));
    send_item(mk(OP_LOAD, CH_CURRENT, 4'd1, 13'd700, 13'd100, 12'd0));
    send_item(mk(OP_MEAS, CH_CURRENT, 4'd0, 13'd0, 13'd0, 12'd50));
    // Falling last segment, sample beyond the table.
    send_item(mk(OP_LOAD, CH_CURRENT, 4'd8, 13'd8191, 13'd3000, 12'd0));
    send_item(mk(OP_MEAS, CH_CURRENT, 4'd0, 13'd0, 13'd0, 12'd4095));
    // Zero-width last segment on the voltage table.
    send_item(mk(OP_LOAD, CH_VOLTAGE, 4'd8, 13'd5000, 13'd3584, 12'd0));
    send_item(mk(OP_MEAS, CH_VOLTAGE, 4'd0, 13'd0, 13'd0, 12'd4000));
    // Low setpoint, sizable current and collapsed voltage raise the flag.
    send_item(mk(OP_SET, CH_CURRENT, 4'd0, 13'd0, 13'd0, 12'd100));
    send_item(mk(OP_MEAS, CH_CURRENT, 4'd0, 13'd0, 13'd0, 12'd1000));
    send_item(mk(OP_MEAS, CH_VOLTAGE, 4'd0, 13'd0, 13'd0, 12'd0));
    // Extrapolation below the table goes negative and clamps to zero.
    send_item(mk(OP_LOAD, CH_VOLTAGE, 4'd0, 13'd0, 13'd300, 12'd0));
    send_item(mk(OP_MEAS, CH_VOLTAGE, 4'd0, 13'd0, 13'd0, 12'd0));
    send_item(mk(OP_LOAD, CH_VOLTAGE, 4'd0, 13'd8191, 13'd0, 12'd0));
    send_item(mk(OP_MEAS, CH_VOLTAGE, 4'd0, 13'd0, 13'd0, 12'd0));
    settle();

    write_regs(16'($urandom_range(8000, 20000)), 16'($urandom_range(1000, 5000)),
               16'($urandom_range(0, 500)), 16'($urandom_range(0, 20000)),
               16'($urandom_range(0, 2000)));
    run_phase(0, 0, 110, 1'b0);

    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(65, 0, 110, 1'b0);

    write_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(0, 65, 110, 1'b0);

    write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
    run_phase(24, 24, 110, 1'b0);

    write_regs(RST_VOLTAGE_GAIN, RST_CURRENT_GAIN, RST_LIMIT_MARGIN,
               RST_LOW_VOLTAGE, RST_MIN_CURRENT);
    run_phase(0, 0, 100, 1'b1);

    write_regs(16'($urandom_range(8000, 20000)), 16'($urandom_range(1000, 5000)),
               16'($urandom_range(0, 500)), 16'($urandom_range(0, 20000)),
               16'($urandom_range(0, 2000)));
    run_phase(24, 24, 110, 1'b0);

    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("Sent %0d items (%0d table loads, %0d conversions) with %0d register writes.",
             items_sent, loads_sent, conversions_sent, reg_writes);
    $display("Compared %0d results over six idle/stall phases with one long output hold.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
